/* hw/rtl/afp_pkg.sv */
package afp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned MM_W    = 19;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned LEFT_W  = 3;
  localparam int unsigned PAY_N   = 5;
  localparam int unsigned RANGE_W = 2;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 128;

  // header codes, compared after masking the two low bits
  localparam logic [7:0] HDR_MASK  = 8'hFC;
  localparam logic [7:0] HDR_ACCEL = 8'h84;
  localparam logic [7:0] HDR_TIME  = 8'h44;
  localparam logic [7:0] HDR_SKIP  = 8'h40;
  localparam logic [7:0] HDR_CFG   = 8'h48;
  localparam logic [7:0] HDR_DROP  = 8'h50;

  localparam logic [LEFT_W-1:0] ACCEL_BYTES = 3'd6;
  localparam logic [LEFT_W-1:0] TIME_BYTES  = 3'd3;
  localparam logic [LEFT_W-1:0] SHORT_BYTES = 3'd1;

  localparam logic CFG_IDX_CAPACITY = 1'b0;
  localparam logic CFG_IDX_RANGE    = 1'b1;

  localparam logic [CNT_W-1:0]   CAPACITY_RST = 16'hFFFF;
  localparam logic [RANGE_W-1:0] RANGE_RST    = 2'd1;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // mm/s^2 = round(|raw| * 980665 / Den), Den = 100 * LSB per g.
  // Evaluated as (|raw| * Recip + 2^(Shift-1)) >> Shift with Recip rounded up;
  // the excess stays below 1/Den over the whole 16-bit range, so it is exact.
  localparam int unsigned SCALE_SHIFT = 36;
  localparam longint unsigned G_MICRO = 64'd980665;
  localparam longint unsigned DEN_R3  = 64'd136500;
  localparam longint unsigned DEN_R2  = DEN_R3 * 2;
  localparam longint unsigned DEN_R1  = DEN_R3 * 4;
  localparam longint unsigned DEN_R0  = DEN_R3 * 8;
  localparam longint unsigned RECIP_R0 = ((G_MICRO << SCALE_SHIFT) + DEN_R0 - 1) / DEN_R0;
  localparam longint unsigned RECIP_R1 = ((G_MICRO << SCALE_SHIFT) + DEN_R1 - 1) / DEN_R1;
  localparam longint unsigned RECIP_R2 = ((G_MICRO << SCALE_SHIFT) + DEN_R2 - 1) / DEN_R2;
  localparam longint unsigned RECIP_R3 = ((G_MICRO << SCALE_SHIFT) + DEN_R3 - 1) / DEN_R3;
  localparam int unsigned RECIP_W = 40;
  localparam int unsigned PROD_W  = RAW_W + RECIP_W;
  localparam int unsigned Q_W     = MM_W - 1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ACCEL,
    PH_SKIP,
    PH_STOPPED
  } afp_phase_t;

  typedef struct packed {
    logic                    kind;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic signed [MM_W-1:0]  mm_x;
    logic signed [MM_W-1:0]  mm_y;
    logic signed [MM_W-1:0]  mm_z;
    logic [CNT_W-1:0]        count;
    logic                    ok;
    logic                    last;
  } afp_result_t;

  typedef struct packed {
    logic first;
    logic second;
  } afp_push_t;

endpackage

/* hw/rtl/afp_scale.sv */
module afp_scale (
  input  logic signed [afp_pkg::RAW_W-1:0]   raw,
  input  logic        [afp_pkg::RANGE_W-1:0] range_code,
  output logic signed [afp_pkg::MM_W-1:0]    mm
);

  logic                              neg;
  logic [afp_pkg::RAW_W-1:0]         mag;
  logic [afp_pkg::RECIP_W-1:0]       recip;
  logic [afp_pkg::PROD_W-1:0]        prod;
  logic [afp_pkg::Q_W-1:0]           q;

  always_comb begin
    neg = raw[afp_pkg::RAW_W-1];
    mag = neg ? (~raw + 1'b1) : raw;
    unique case (range_code)
      2'd0:    recip = afp_pkg::RECIP_W'(afp_pkg::RECIP_R0);
      2'd1:    recip = afp_pkg::RECIP_W'(afp_pkg::RECIP_R1);
      2'd2:    recip = afp_pkg::RECIP_W'(afp_pkg::RECIP_R2);
      default: recip = afp_pkg::RECIP_W'(afp_pkg::RECIP_R3);
    endcase
    prod = (afp_pkg::PROD_W'(mag) * afp_pkg::PROD_W'(recip))
         + (afp_pkg::PROD_W'(1) << (afp_pkg::SCALE_SHIFT - 1));
    q    = prod[afp_pkg::SCALE_SHIFT +: afp_pkg::Q_W];
    mm   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

endmodule

/* hw/rtl/afp_parser.sv */
module afp_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  logic [afp_pkg::BYTE_W-1:0]        fifo_byte,
  input  logic                              final_byte,
  input  logic [afp_pkg::CNT_W-1:0]         capacity,
  input  logic [afp_pkg::RANGE_W-1:0]       range_code,
  output afp_pkg::afp_push_t                push,
  output afp_pkg::afp_result_t              res_first,
  output afp_pkg::afp_result_t              res_second
);

  afp_pkg::afp_phase_t             phase_r, phase_nxt;
  logic [afp_pkg::LEFT_W-1:0]      left_r, left_nxt;
  logic [afp_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [afp_pkg::BYTE_W-1:0]      pay_r [afp_pkg::PAY_N];
  logic [afp_pkg::BYTE_W-1:0]      pay_nxt [afp_pkg::PAY_N];
  logic [afp_pkg::BYTE_W-1:0]      hdr;
  logic [afp_pkg::LEFT_W-1:0]      pay_idx;
  logic                            sample;
  logic signed [afp_pkg::RAW_W-1:0] raw_x, raw_y, raw_z;
  logic signed [afp_pkg::MM_W-1:0]  mm_x, mm_y, mm_z;
  afp_pkg::afp_result_t            smp_res, sum_res;

  assign raw_x = $signed({pay_r[1], pay_r[0]});
  assign raw_y = $signed({pay_r[3], pay_r[2]});
  assign raw_z = $signed({fifo_byte, pay_r[4]});

  afp_scale u_scale_x (.raw(raw_x), .range_code(range_code), .mm(mm_x));
  afp_scale u_scale_y (.raw(raw_y), .range_code(range_code), .mm(mm_y));
  afp_scale u_scale_z (.raw(raw_z), .range_code(range_code), .mm(mm_z));

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    cnt_nxt   = cnt_r;
    pay_nxt   = pay_r;
    sample    = 1'b0;
    hdr       = fifo_byte & afp_pkg::HDR_MASK;
    pay_idx   = afp_pkg::ACCEL_BYTES - left_r;

    unique case (phase_r)
      afp_pkg::PH_HEADER: begin
        if (cnt_r >= capacity) begin
          phase_nxt = afp_pkg::PH_STOPPED;
        end else if (hdr == afp_pkg::HDR_ACCEL) begin
          phase_nxt = afp_pkg::PH_ACCEL;
          left_nxt  = afp_pkg::ACCEL_BYTES;
        end else if (hdr == afp_pkg::HDR_TIME) begin
          phase_nxt = afp_pkg::PH_SKIP;
          left_nxt  = afp_pkg::TIME_BYTES;
        end else if (hdr == afp_pkg::HDR_SKIP || hdr == afp_pkg::HDR_CFG ||
                     hdr == afp_pkg::HDR_DROP) begin
          phase_nxt = afp_pkg::PH_SKIP;
          left_nxt  = afp_pkg::SHORT_BYTES;
        end else begin
          phase_nxt = afp_pkg::PH_STOPPED;
        end
      end
      afp_pkg::PH_SKIP: begin
        left_nxt = left_r - 1'b1;
        if (left_nxt == '0) phase_nxt = afp_pkg::PH_HEADER;
      end
      afp_pkg::PH_ACCEL: begin
        if (left_r > 3'd1 && left_r <= afp_pkg::ACCEL_BYTES) begin
          for (int i = 0; i < afp_pkg::PAY_N; i++) begin
            if (pay_idx == afp_pkg::LEFT_W'(i)) pay_nxt[i] = fifo_byte;
          end
          left_nxt = left_r - 1'b1;
        end else begin
          sample    = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          left_nxt  = '0;
          phase_nxt = afp_pkg::PH_HEADER;
        end
      end
      default: begin
        // stopped: drop every byte until the burst ends
      end
    endcase

    smp_res.kind  = afp_pkg::KIND_SAMPLE;
    smp_res.raw_x = raw_x;
    smp_res.raw_y = raw_y;
    smp_res.raw_z = raw_z;
    smp_res.mm_x  = mm_x;
    smp_res.mm_y  = mm_y;
    smp_res.mm_z  = mm_z;
    smp_res.count = cnt_nxt;
    smp_res.ok    = 1'b0;
    smp_res.last  = ~final_byte;

    sum_res       = '0;
    sum_res.kind  = afp_pkg::KIND_SUMMARY;
    sum_res.count = cnt_nxt;
    sum_res.ok    = (cnt_nxt != '0);
    sum_res.last  = 1'b1;

    res_first   = sample ? smp_res : sum_res;
    res_second  = sum_res;
    push.first  = take & (sample | final_byte);
    push.second = take & sample & final_byte;

    if (final_byte) begin
      phase_nxt = afp_pkg::PH_HEADER;
      left_nxt  = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= afp_pkg::PH_HEADER;
      left_r  <= '0;
      cnt_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) pay_r <= pay_nxt;
  end

endmodule

/* hw/rtl/afp_result_fifo.sv */
module afp_result_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  afp_pkg::afp_push_t   push,
  input  afp_pkg::afp_result_t wr_first,
  input  afp_pkg::afp_result_t wr_second,
  output logic                 room,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output afp_pkg::afp_result_t rd_data
);

  afp_pkg::afp_result_t mem_r [4];
  logic [1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic                 pop;

  assign rd_valid = (cnt_r != 3'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  // space for two results per request
  assign room     = (cnt_r <= 3'd2);
  assign pop      = rd_valid & rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + 2'(push.first) + 2'(push.second);
    rd_ptr_nxt = rd_ptr_r + 2'(pop);
    cnt_nxt    = cnt_r + 3'(push.first) + 3'(push.second) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first)  mem_r[wr_ptr_r]        <= wr_first;
    if (push.second) mem_r[wr_ptr_r + 2'd1] <= wr_second;
  end

endmodule

/* hw/rtl/accel_fifo_frame_parser_unit.sv */
// Channel | Dir | Accept             | Payload
// in_     | in  | tvalid & tready    | tdata: fifo_byte; tlast: final_byte
// out_    | out | tvalid & tready    | tdata: raw/mm/count/ok; tuser: item_kind; tlast: last_of_run
// cfg_    | in  | cfg_we             | cfg_index selects register, cfg_wdata value
//
// A byte is parsed in the cycle it is taken; its results sit in the four-entry
// result queue from the next cycle on. One byte per cycle is sustained while the
// consumer keeps up; a byte that ends a frame and the burst yields two results,
// a sample and a summary. in_tready drops while the queue has room for fewer than
// two results. Reset (rst_n low, synchronous) empties the queue and returns to header parsing.
module accel_fifo_frame_parser_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [afp_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] fifo_byte
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] raw_x, [31:16] raw_y, [47:32] raw_z, [66:48] accel_x_mm,
  // [85:67] accel_y_mm, [104:86] accel_z_mm, [120:105] sample_count,
  // [121] parse_ok, [127:122] zero
  output logic [afp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser,  // [0] item_kind
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [afp_pkg::CFG_W-1:0]          cfg_wdata
);

  logic [afp_pkg::CNT_W-1:0]   cap_r;
  logic [afp_pkg::RANGE_W-1:0] range_r;
  logic                        take;
  logic                        room;
  afp_pkg::afp_push_t          push;
  afp_pkg::afp_result_t        res_first, res_second, rd_data;

  assign in_tready = room;
  assign take      = in_tvalid & room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= afp_pkg::CAPACITY_RST;
      range_r <= afp_pkg::RANGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afp_pkg::CFG_IDX_CAPACITY: cap_r   <= cfg_wdata;
        afp_pkg::CFG_IDX_RANGE:    range_r <= cfg_wdata[afp_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  afp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .fifo_byte  (in_tdata[afp_pkg::BYTE_W-1:0]),
    .final_byte (in_tlast),
    .capacity   (cap_r),
    .range_code (range_r),
    .push       (push),
    .res_first  (res_first),
    .res_second (res_second)
  );

  afp_result_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_first  (res_first),
    .wr_second (res_second),
    .room      (room),
    .rd_valid  (out_tvalid),
    .rd_ready  (out_tready),
    .rd_data   (rd_data)
  );

  assign out_tdata = {6'd0, rd_data.ok, rd_data.count, rd_data.mm_z, rd_data.mm_y,
                      rd_data.mm_x, rd_data.raw_z, rd_data.raw_y, rd_data.raw_x};
  assign out_tuser = rd_data.kind;
  assign out_tlast = rd_data.last;

endmodule

/* bench/accel_fifo_frame_parser_unit_test.sv */
module accel_fifo_frame_parser_unit_test;
  import afp_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_SET = 80;

  class burst_scoreboard;
    afp_result_t       pending_results[$];
    int                failures;
    logic [CNT_W-1:0]  capacity;
    logic [RANGE_W-1:0] range_sel;
    afp_phase_t        phase;
    logic [LEFT_W-1:0] left;
    logic [7:0]        payload[PAY_N];
    logic [CNT_W-1:0]  emitted;

    function new();
      failures = 0;
      capacity = CAPACITY_RST;
      range_sel = RANGE_RST;
      phase = PH_HEADER;
      left = '0;
      emitted = '0;
      foreach (payload[i]) payload[i] = '0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_IDX_CAPACITY) capacity = value;
      else range_sel = value[RANGE_W-1:0];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // round |raw| * g / (100 * LSB per g) to nearest, ties away from zero
    function logic signed [MM_W-1:0] scale_mm(logic signed [RAW_W-1:0] raw);
      longint den;
      longint r;
      longint mag;
      longint q;
      case (range_sel)
        2'd0: den = 100 * 10920;
        2'd1: den = 100 * 5460;
        2'd2: den = 100 * 2730;
        default: den = 100 * 1365;
      endcase
      r = raw;
      mag = (r < 0) ? -r : r;
      q = (2 * mag * 980665 + den) / (2 * den);
      return (r < 0) ? MM_W'(-q) : MM_W'(q);
    endfunction

    // advance the parser by one byte and queue the results it causes
    function void parse_byte(logic [7:0] b, logic fin);
      afp_result_t r;
      logic [7:0] h;
      case (phase)
        PH_HEADER: begin
          if (emitted >= capacity) begin
            phase = PH_STOPPED;
          end else begin
            h = b & HDR_MASK;
            if (h == HDR_ACCEL) begin
              phase = PH_ACCEL;
              left = ACCEL_BYTES;
            end else if (h == HDR_TIME) begin
              phase = PH_SKIP;
              left = TIME_BYTES;
            end else if (h == HDR_SKIP || h == HDR_CFG || h == HDR_DROP) begin
              phase = PH_SKIP;
              left = SHORT_BYTES;
            end else begin
              phase = PH_STOPPED;
            end
          end
        end
        PH_SKIP: begin
          left = left - 3'd1;
          if (left == 0) phase = PH_HEADER;
        end
        PH_ACCEL: begin
          if (left > 1 && left <= ACCEL_BYTES) begin
            payload[int'(ACCEL_BYTES) - int'(left)] = b;
            left = left - 3'd1;
          end else begin
            r = '0;
            r.kind = KIND_SAMPLE;
            r.raw_x = {payload[1], payload[0]};
            r.raw_y = {payload[3], payload[2]};
            r.raw_z = {b, payload[4]};
            r.mm_x = scale_mm(r.raw_x);
            r.mm_y = scale_mm(r.raw_y);
            r.mm_z = scale_mm(r.raw_z);
            emitted = emitted + 1'b1;
            r.count = emitted;
            r.ok = 1'b0;
            r.last = !fin;
            pending_results.push_back(r);
            left = '0;
            phase = PH_HEADER;
          end
        end
        default: ;
      endcase
      if (fin) begin
        r = '0;
        r.kind = KIND_SUMMARY;
        r.count = emitted;
        r.ok = (emitted != 0);
        r.last = 1'b1;
        pending_results.push_back(r);
        phase = PH_HEADER;
        left = '0;
        emitted = '0;
      end
    endfunction

    function void report(string what, longint e, longint a);
      failures++;
      if (failures <= 10)
        $display("mismatch on %s: expected %0d, got %0d", what, e, a);
    endfunction

    function void check_result(afp_result_t got);
      afp_result_t e;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result with nothing pending: kind %0d count %0d last %0d",
                   got.kind, got.count, got.last);
        return;
      end
      e = pending_results.pop_front();
      if (got.kind != e.kind) report("item_kind", e.kind, got.kind);
      if (got.raw_x != e.raw_x) report("raw_x", longint'(e.raw_x), longint'(got.raw_x));
      if (got.raw_y != e.raw_y) report("raw_y", longint'(e.raw_y), longint'(got.raw_y));
      if (got.raw_z != e.raw_z) report("raw_z", longint'(e.raw_z), longint'(got.raw_z));
      if (got.mm_x != e.mm_x) report("accel_x_mm", longint'(e.mm_x), longint'(got.mm_x));
      if (got.mm_y != e.mm_y) report("accel_y_mm", longint'(e.mm_y), longint'(got.mm_y));
      if (got.mm_z != e.mm_z) report("accel_z_mm", longint'(e.mm_z), longint'(got.mm_z));
      if (got.count != e.count) report("sample_count", e.count, got.count);
      if (got.ok != e.ok) report("parse_ok", e.ok, got.ok);
      if (got.last != e.last) report("last_of_run", e.last, got.last);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;

  burst_scoreboard sb;
  bit quiet;
  int hold_req;
  int sent_items;
  int stall_cycles;

  int cap_set[7] = '{65535, 0, 1, 3, 65535, 2, 100};
  int range_set[7] = '{0, 3, 2, 1, 3, 0, 2};

  accel_fifo_frame_parser_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [15:0] pick_word();
    if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    sb.parse_byte(b, fin);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_burst(input logic [7:0] bq[$]);
    for (int i = 0; i < bq.size(); i++) send_byte(bq[i], i == bq.size() - 1);
  endtask

  task automatic run_burst(input int nframes, input int accel_pct);
    logic [7:0] bq[$];
    logic [15:0] w;
    logic [7:0] b;
    int cut;
    for (int f = 0; f < nframes; f++) begin
      if ($urandom_range(0, 99) < accel_pct) begin
        bq.push_back(HDR_ACCEL | 8'($urandom_range(0, 3)));
        repeat (3) begin
          w = pick_word();
          bq.push_back(w[7:0]);
          bq.push_back(w[15:8]);
        end
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            bq.push_back(HDR_TIME | 8'($urandom_range(0, 3)));
            repeat (3) bq.push_back(8'($urandom_range(0, 255)));
          end
          4, 5, 6, 7: begin
            case ($urandom_range(0, 2))
              0: b = HDR_SKIP;
              1: b = HDR_CFG;
              default: b = HDR_DROP;
            endcase
            bq.push_back(b | 8'($urandom_range(0, 3)));
            bq.push_back(8'($urandom_range(0, 255)));
          end
          8: begin
            // unknown header
            do b = 8'($urandom_range(0, 255));
            while ((b & HDR_MASK) == HDR_ACCEL || (b & HDR_MASK) == HDR_TIME ||
                   (b & HDR_MASK) == HDR_SKIP || (b & HDR_MASK) == HDR_CFG ||
                   (b & HDR_MASK) == HDR_DROP);
            bq.push_back(b);
            bq.push_back(8'($urandom_range(0, 255)));
          end
          default: bq.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    // cut the burst short now and then
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, bq.size());
      while (bq.size() > cut) void'(bq.pop_back());
    end
    send_burst(bq);
  endtask

  // drop the request line and wait until every pending result has come back
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req > 0) begin
        gap = hold_req;
        hold_req = 0;
      end else begin
        gap = draw_gap();
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result('{kind:  out_tuser,
                        raw_x: out_tdata[15:0],
                        raw_y: out_tdata[31:16],
                        raw_z: out_tdata[47:32],
                        mm_x:  out_tdata[66:48],
                        mm_y:  out_tdata[85:67],
                        mm_z:  out_tdata[104:86],
                        count: out_tdata[120:105],
                        ok:    out_tdata[121],
                        last:  out_tlast});
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int start;
    int bursts;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_IDX_CAPACITY;
    cfg_wdata = '0;
    quiet = 1'b0;
    hold_req = 0;
    sent_items = 0;
    stall_cycles = 0;
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every frame kind, extreme counts, sample on the final byte
    send_burst('{8'h84, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF,
                 8'h47, 8'h01, 8'h02, 8'h03, 8'h41, 8'hAA, 8'h4A, 8'h55,
                 8'h53, 8'h00, 8'h87, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFE, 8'hFF});
    // truncated acceleration frame
    send_burst('{8'h85, 8'h12, 8'h34});
    // time frame cut short
    send_burst('{8'h46, 8'h00});
    // unknown header on the final byte: empty summary
    send_burst('{8'hFF});
    wait_results();

    for (int p = 0; p < 7; p++) begin
      cfg_write(CFG_IDX_CAPACITY, CFG_W'(cap_set[p]));
      cfg_write(CFG_IDX_RANGE, CFG_W'(range_set[p]));
      @(negedge clk);
      start = sent_items;
      bursts = 0;
      if (p == 0) begin
        // hold the receiver off while samples pile up behind it
        quiet = 1'b1;
        hold_req = 300;
        run_burst(14, 100);
        quiet = 1'b0;
        wait_results();
      end
      while (sent_items - start < ITEMS_PER_SET && bursts < 40) begin
        quiet = ($urandom_range(0, 4) == 0);
        run_burst($urandom_range(1, 5), 60);
        bursts++;
      end
      quiet = 1'b0;
      wait_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
